>>> sv/hcbp_pkg.sv
// shared types and constants for the huffman code bit packer
package hcbp_pkg;

   localparam int SYMBOL_COUNT_DEF = 256;
   localparam int MAX_CODE_LEN_DEF = 32;

   localparam int SYMBOL_W  = 8;
   localparam int WORD_W    = 32;
   localparam int LENGTH_W  = 6;
   localparam int ACTION_W  = 2;
   localparam int BYTE_W    = 8;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 1;

   localparam int SYMBOL_LSB = 0;
   localparam int WORD_LSB   = SYMBOL_LSB + SYMBOL_W;
   localparam int LENGTH_LSB = WORD_LSB + WORD_W;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD   = 2'd0,
      ACT_ENCODE = 2'd1,
      ACT_FLUSH  = 2'd2
   } hcbp_action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_EMIT,
      ST_FLUSH
   } hcbp_state_type;

   typedef struct packed {
      logic table_write;
      logic table_read;
      logic align;
      logic emit;
      logic commit;
      logic flush_out;
   } hcbp_cmd_type;

   typedef struct packed {
      logic in_range;
      logic has_byte;
      logic out_free;
   } hcbp_status_type;

endpackage

>>> sv/hcbp_ctrl.sv
// controller state machine for the huffman code bit packer
module hcbp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [hcbp_pkg::ACTION_W-1:0] req_tuser,
   input  hcbp_pkg::hcbp_status_type status,
   output hcbp_pkg::hcbp_cmd_type    cmd
);
   import hcbp_pkg::*;

   hcbp_state_type  state_ff;
   hcbp_state_type  state_in;
   hcbp_action_type action;
   logic            accept;

   assign action     = hcbp_action_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (action)
                  ACT_ENCODE: begin
                     if (status.in_range) begin
                        state_in = ST_ALIGN;
                     end
                  end
                  ACT_FLUSH: state_in = ST_FLUSH;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_ALIGN: state_in = ST_EMIT;
         ST_EMIT: begin
            if (!status.has_byte) begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.table_write = accept & (action == ACT_LOAD) & status.in_range;
            cmd.table_read  = accept & (action == ACT_ENCODE) & status.in_range;
         end
         ST_ALIGN: cmd.align = 1'b1;
         ST_EMIT: begin
            cmd.emit   = status.has_byte & status.out_free;
            cmd.commit = !status.has_byte;
         end
         ST_FLUSH: cmd.flush_out = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

>>> sv/hcbp_datapath.sv
// code table, bit accumulator and output register of the huffman code bit packer
module hcbp_datapath #(
   parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF,
   parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [hcbp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  hcbp_pkg::hcbp_cmd_type          cmd,
   output hcbp_pkg::hcbp_status_type       status,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [hcbp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast,
   output logic [hcbp_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import hcbp_pkg::*;

   localparam int ADDR_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
   localparam int ACC_W   = MAX_CODE_LEN + BYTE_W;
   localparam int TOTAL_W = $clog2(MAX_CODE_LEN + BYTE_W);
   localparam int ENTRY_W = MAX_CODE_LEN + LEN_W;

   logic [SYMBOL_W-1:0] symbol;
   logic [WORD_W-1:0]   code_word;
   logic [LENGTH_W-1:0] code_length;
   logic [LEN_W-1:0]    load_len;
   logic [LENGTH_W-1:0] load_shamt;
   logic [WORD_W-1:0]   load_shift;
   logic [ADDR_W-1:0]   addr;

   logic [ENTRY_W-1:0]  code_mem [SYMBOL_COUNT];
   logic [ENTRY_W-1:0]  rd_entry_ff;
   logic [MAX_CODE_LEN-1:0] rd_word;
   logic [LEN_W-1:0]    rd_len;

   logic [ACC_W-1:0]    acc_ff;
   logic [ACC_W-1:0]    acc_in;
   logic [TOTAL_W-1:0]  total_ff;
   logic [TOTAL_W-1:0]  total_in;
   logic [BYTE_W-1:0]   partial_ff;
   logic [BYTE_W-1:0]   partial_in;
   logic [2:0]          used_ff;
   logic [2:0]          used_in;

   logic                out_valid_ff;
   logic                out_valid_in;
   logic [BYTE_W-1:0]   out_byte_ff;
   logic [BYTE_W-1:0]   out_byte_in;
   logic                out_last_ff;
   logic                out_last_in;
   logic                out_eos_ff;
   logic                out_eos_in;

   assign symbol      = req_tdata[SYMBOL_LSB +: SYMBOL_W];
   assign code_word   = req_tdata[WORD_LSB +: WORD_W];
   assign code_length = req_tdata[LENGTH_LSB +: LENGTH_W];
   assign addr        = symbol[ADDR_W-1:0];

   // saturate the length and left-align the code, dropping bits above the length
   assign load_len   = (code_length > LENGTH_W'(MAX_CODE_LEN)) ?
                       LEN_W'(MAX_CODE_LEN) : LEN_W'(code_length);
   assign load_shamt = LENGTH_W'(MAX_CODE_LEN) - LENGTH_W'(load_len);
   assign load_shift = code_word << load_shamt;

   always_ff @(posedge clock) begin
      if (cmd.table_write) begin
         code_mem[addr] <= {load_shift[MAX_CODE_LEN-1:0], load_len};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.table_read) begin
         rd_entry_ff <= code_mem[addr];
      end
   end

   assign rd_word = rd_entry_ff[LEN_W +: MAX_CODE_LEN];
   assign rd_len  = rd_entry_ff[LEN_W-1:0];

   assign status.in_range = ({1'b0, symbol} < (SYMBOL_W + 1)'(SYMBOL_COUNT));
   assign status.has_byte = |total_ff[TOTAL_W-1:3];
   assign status.out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      acc_in   = acc_ff;
      total_in = total_ff;
      if (cmd.align) begin
         acc_in   = {partial_ff, {MAX_CODE_LEN{1'b0}}} |
                    ({rd_word, {BYTE_W{1'b0}}} >> used_ff);
         total_in = TOTAL_W'(used_ff) + TOTAL_W'(rd_len);
      end else if (cmd.emit) begin
         acc_in   = acc_ff << BYTE_W;
         total_in = total_ff - TOTAL_W'(BYTE_W);
      end
   end

   always_comb begin
      partial_in = partial_ff;
      used_in    = used_ff;
      if (cmd.commit) begin
         partial_in = acc_ff[ACC_W-1 -: BYTE_W];
         used_in    = total_ff[2:0];
      end else if (cmd.flush_out) begin
         partial_in = '0;
         used_in    = '0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff & !rsp_tready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_eos_in   = out_eos_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = acc_ff[ACC_W-1 -: BYTE_W];
         out_last_in  = (total_ff[TOTAL_W-1:3] == (TOTAL_W - 3)'(1));
         out_eos_in   = 1'b0;
      end else if (cmd.flush_out) begin
         out_valid_in = 1'b1;
         out_byte_in  = partial_ff;
         out_last_in  = 1'b1;
         out_eos_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff   <= '0;
         used_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         partial_ff   <= partial_in;
         used_ff      <= used_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      total_ff    <= total_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_eos_ff  <= out_eos_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_eos_ff;

endmodule

>>> sv/huffman_code_bit_packer.sv
// top level of the huffman code bit packer: controller plus datapath
//
//   channel  direction  tdata (low bit up)                       tuser / tlast
//   req_     in         symbol[7:0] code_word[39:8] length[45:40] tuser action
//   rsp_     out        out_byte[7:0]                            tuser end_of_stream,
//                                                                tlast last_of_run
//
// load and action 3 finish in the idle state; flush uses the flush step; encode
// uses the registered table read, the align step and the emit step, which sends
// up to 4 bytes via the one-byte output register; an out-of-range encode is dropped.
// synchronous reset clears the pending bits and the output valid; the table is
// not cleared. a stalled rsp_ side holds the packer in its emit or flush step.
module huffman_code_bit_packer #(
   parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF,
   parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // symbol, code_word, code_length, two zero bits
   input  logic [hcbp_pkg::REQ_DATA_W-1:0] req_tdata,
   // action
   input  logic [hcbp_pkg::ACTION_W-1:0]   req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_byte
   output logic [hcbp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast,
   // end_of_stream
   output logic [hcbp_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import hcbp_pkg::*;

   hcbp_cmd_type    cmd;
   hcbp_status_type status;

   hcbp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   hcbp_datapath #(
      .SYMBOL_COUNT (SYMBOL_COUNT),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
